// ===== rtl/pfb_pkg.sv =====
package pfb_pkg;

	// Store geometry
	localparam int MAX_WIDTH   = 128;
	localparam int MAX_PAGES   = 8;
	localparam int STORE_BYTES = MAX_WIDTH * MAX_PAGES;
	localparam int ADDR_W      = $clog2(STORE_BYTES);

	// Configuration widths
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int WID_W      = 8;
	localparam int HGT_W      = 7;
	localparam int ROT_W      = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 2'd2;

	// Reset values
	localparam logic [WID_W-1:0] WIDTH_RST  = 8'd128;
	localparam logic [HGT_W-1:0] HEIGHT_RST = 7'd64;
	localparam logic [ROT_W-1:0] ROT_RST    = 2'd0;

	// Operation codes
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_PLOT  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Color codes
	localparam logic [1:0] COL_CLR  = 2'd0;
	localparam logic [1:0] COL_SET  = 2'd1;
	localparam logic [1:0] COL_TOG  = 2'd2;
	localparam logic [1:0] COL_KEEP = 2'd3;

	// Rotation modes
	localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
	localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
	localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
	localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

	// Classified command kinds
	localparam logic [1:0] CMD_NOP   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_PLOT  = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	// Command queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] addr;
		logic [2:0]        bit_sel;
		logic [1:0]        color;
	} qent_t;

endpackage

// ===== rtl/pfb_if.sv =====
interface pfb_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic signed [8:0] pos_x;
	logic signed [8:0] pos_y;
	logic [1:0]        color;
	logic [9:0]        byte_index;

	modport source (output valid, op, pos_x, pos_y, color, byte_index, input ready);
	modport sink   (input valid, op, pos_x, pos_y, color, byte_index, output ready);
endinterface

interface pfb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       pixel_written;

	modport source (output valid, read_data, pixel_written, input ready);
	modport sink   (input valid, read_data, pixel_written, output ready);
endinterface

// ===== rtl/pfb_queue.sv =====
module pfb_queue import pfb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  qent_t wr_data,
	output logic  rd_valid,
	input  logic  rd_ready,
	output qent_t rd_data
);

	qent_t             entries_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign wr_ready = count_q != QCNT_W'(QDEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = entries_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not grow on push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers apart while empty");
`endif

endmodule

// ===== rtl/pfb_front.sv =====
module pfb_front import pfb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	pfb_in_if.sink           cmd,
	input  logic             hold,
	input  logic [WID_W-1:0] width_in_use,
	input  logic [HGT_W-1:0] height_in_use,
	input  logic [ROT_W-1:0] rotation_mode,
	output logic             push_valid,
	input  logic             push_ready,
	output qent_t            push_data
);

	logic signed [10:0] xs, ys, ws, hs, rx, ry;
	logic               in_bounds;
	logic               plot_ok;
	logic               read_ok;
	logic [15:0]        bi_ext;
	logic [1:0]         kind_d;
	logic               take;

	logic              valid_s1;
	logic [1:0]        kind_s1;
	logic [7:0]        rx_s1;
	logic [7:0]        ry_s1;
	logic [1:0]        color_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic [12:0] page_base;
	logic [13:0] idx;
	logic        idx_ok;

	// Classify and rotate
	always_comb begin
		xs = {{2{cmd.pos_x[8]}}, cmd.pos_x};
		ys = {{2{cmd.pos_y[8]}}, cmd.pos_y};
		ws = {3'b000, width_in_use};
		hs = {4'b0000, height_in_use};
		in_bounds = !xs[10] && (xs < ws) && !ys[10] && (ys < hs);
		case (rotation_mode)
			ROT_90: begin
				rx = ws - ys - 11'sd1;
				ry = xs;
			end
			ROT_180: begin
				rx = ws - xs - 11'sd1;
				ry = hs - ys - 11'sd1;
			end
			ROT_270: begin
				rx = ys;
				ry = hs - xs - 11'sd1;
			end
			default: begin
				rx = xs;
				ry = ys;
			end
		endcase
		plot_ok = in_bounds && !rx[10] && !ry[10];
		bi_ext  = 16'(cmd.byte_index);
		read_ok = bi_ext < 16'(STORE_BYTES);
		case (cmd.op)
			OP_CLEAR: kind_d = CMD_CLEAR;
			OP_PLOT:  kind_d = plot_ok ? CMD_PLOT : CMD_NOP;
			OP_READ:  kind_d = read_ok ? CMD_READ : CMD_NOP;
			default:  kind_d = CMD_NOP;
		endcase
	end

	assign cmd.ready = (!valid_s1 || push_ready) && !hold;
	assign take      = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1  <= kind_d;
			rx_s1    <= rx[7:0];
			ry_s1    <= ry[7:0];
			color_s1 <= cmd.color;
			addr_s1  <= bi_ext[ADDR_W-1:0];
		end
	end

	// Byte index and store range check
	always_comb begin
		page_base = 13'(ry_s1[7:3] * width_in_use);
		idx       = 14'(rx_s1) + 14'(page_base);
		idx_ok    = idx < 14'(STORE_BYTES);
		push_data.kind    = (kind_s1 == CMD_PLOT && !idx_ok) ? CMD_NOP : kind_s1;
		push_data.addr    = (kind_s1 == CMD_PLOT) ? idx[ADDR_W-1:0] : addr_s1;
		push_data.bit_sel = ry_s1[2:0];
		push_data.color   = color_s1;
	end

	assign push_valid = valid_s1;

endmodule

// ===== rtl/pfb_back.sv =====
module pfb_back import pfb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_valid,
	output logic     q_ready,
	input  qent_t    q_data,
	pfb_out_if.source rsp,
	output logic     init_busy
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SWEEP = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_PUSH  = 3'd4;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rd_q;

	logic [2:0]        state_q, state_d;
	logic [ADDR_W-1:0] ptr_q;
	logic              rpt_q;
	qent_t             cmd_q;
	logic [7:0]        pend_data_q;
	logic              pend_wr_q;
	logic              out_valid_q;
	logic [7:0]        out_data_q;
	logic              out_wr_q;

	logic              pop;
	logic              out_free;
	logic              res_valid;
	logic [7:0]        res_data;
	logic              res_wr;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic [7:0]        mask;
	logic [7:0]        new_byte;

	assign pop       = q_valid && q_ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign init_busy = (state_q == ST_SWEEP) && !rpt_q;

	always_comb begin
		mask = 8'd1 << cmd_q.bit_sel;
		case (cmd_q.color)
			COL_CLR: new_byte = rd_q & ~mask;
			COL_SET: new_byte = rd_q | mask;
			COL_TOG: new_byte = rd_q ^ mask;
			default: new_byte = rd_q;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		q_ready   = 1'b0;
		res_valid = 1'b0;
		res_data  = '0;
		res_wr    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cmd_q.addr;
		mem_wdata = '0;
		case (state_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					case (q_data.kind)
						CMD_CLEAR: state_d = ST_SWEEP;
						CMD_PLOT:  state_d = ST_MOD;
						CMD_READ:  state_d = ST_RD;
						default:   res_valid = 1'b1;
					endcase
				end
			end
			ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				if (ptr_q == LAST_ADDR) begin
					state_d   = ST_IDLE;
					res_valid = rpt_q;
				end
			end
			ST_MOD: begin
				mem_we    = cmd_q.color != COL_KEEP;
				mem_wdata = new_byte;
				res_valid = 1'b1;
				res_wr    = 1'b1;
			end
			ST_RD: begin
				res_valid = 1'b1;
				res_data  = rd_q;
			end
			ST_PUSH: begin
				res_valid = 1'b1;
				res_data  = pend_data_q;
				res_wr    = pend_wr_q;
			end
			default: state_d = ST_IDLE;
		endcase
		if (res_valid) begin
			state_d = out_free ? ST_IDLE : ST_PUSH;
		end
	end

	// Single write port, registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[q_data.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			ptr_q       <= '0;
			rpt_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && q_data.kind == CMD_CLEAR) begin
				ptr_q <= '0;
				rpt_q <= 1'b1;
			end else if (state_q == ST_SWEEP) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (res_valid && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_data;
		end
		if (res_valid && !out_free) begin
			pend_data_q <= res_data;
			pend_wr_q   <= res_wr;
		end
		if (res_valid && out_free) begin
			out_data_q <= res_data;
			out_wr_q   <= res_wr;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.read_data     = out_data_q;
	assign rsp.pixel_written = out_wr_q;

`ifndef SYNTHESIS
	a_push_holds_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PUSH |-> out_valid_q)
		else $error("result parked while output register empty");
	a_mod_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOD |=> state_q == ST_IDLE || state_q == ST_PUSH)
		else $error("plot write did not finish in one cycle");
	a_sweep_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP && ptr_q != LAST_ADDR |=>
		state_q == ST_SWEEP && ptr_q == ADDR_W'($past(ptr_q) + 1'b1))
		else $error("clear sweep skipped or stopped early");
`endif

endmodule

// ===== rtl/page_framebuffer_pixel_plotter_unit.sv =====
// Channel | Dir | Payload                                  | Transaction
// cmd     | in  | op, pos_x, pos_y, color, byte_index      | valid & ready at clk rise
// rsp     | out | read_data, pixel_written                 | valid & ready at clk rise
// cfg     | in  | cfg_we, cfg_idx, cfg_wdata (no read-back) | cfg_we at clk rise
//
// In the back end, plot and read issue the memory read from idle, then
// modify/write or return; a rejected plot or unknown op is answered from idle.
// Clear sweeps every store byte (STORE_BYTES) through the single write port.
// After reset a clearing pass over all STORE_BYTES zeroes the store; cmd.ready
// stays low meanwhile, configuration writes are taken.
// A front stage plus a two-entry queue decouple cmd from the back end, and a
// result register lets the back end park one result while rsp stalls.
module page_framebuffer_pixel_plotter_unit import pfb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	pfb_in_if.sink                cmd,
	pfb_out_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [WID_W-1:0] width_q;
	logic [HGT_W-1:0] height_q;
	logic [ROT_W-1:0] rotation_q;

	logic  push_valid;
	logic  push_ready;
	qent_t push_data;
	logic  q_valid;
	logic  q_ready;
	qent_t q_data;
	logic  init_busy;

	// Configuration registers; writes to an unused index drop silently
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
			rotation_q <= ROT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_WIDTH:    width_q    <= cfg_wdata[WID_W-1:0];
				CFG_HEIGHT:   height_q   <= cfg_wdata[HGT_W-1:0];
				CFG_ROTATION: rotation_q <= cfg_wdata[ROT_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: bounds check, rotation, byte index, classification
	pfb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.hold          (init_busy),
		.width_in_use  (width_q),
		.height_in_use (height_q),
		.rotation_mode (rotation_q),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_data     (push_data)
	);

	// Queue between classification and store access
	pfb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  (push_data),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_data)
	);

	// Back: store, read-modify-write, clear sweep, result register
	pfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.rsp       (rsp),
		.init_busy (init_busy)
	);

endmodule

// ===== verif/tb_top.sv =====
module tb_top import pfb_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// The package names no code for the spare op value; the block treats it as a no-op.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Number of mismatches that get printed in full; later ones are only counted.
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [1:0]        op;
		logic signed [8:0] pos_x;
		logic signed [8:0] pos_y;
		logic [1:0]        color;
		logic [9:0]        byte_index;
	} pixel_cmd_t;

	typedef struct {
		logic [7:0] read_data;
		logic       pixel_written;
	} pixel_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pfb_in_if  cmd_if ();
	pfb_out_if rsp_if ();

	page_framebuffer_pixel_plotter_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the framebuffer and of the panel registers, kept in step
	// with every accepted command transaction.
	logic [7:0]       frame_bytes [STORE_BYTES];
	logic [WID_W-1:0] panel_width;
	logic [HGT_W-1:0] panel_height;
	logic [ROT_W-1:0] panel_rotation;
	int               last_plot_pos;

	// Results still owed by the block, oldest first.
	pixel_result_t pending_results [$];
	int            mismatch_count;

	// Traffic shaping knobs, in percent per cycle.
	int send_idle_pct;
	int rx_stall_pct;

	// Long response hold-off: the test posts a length, the receiver counts it down.
	int hold_off_request;
	int hold_off_left;

	always #1 clk = ~clk;

	// Hard stop in case the block hangs.
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Work out what one command does to the shadow framebuffer and what the
	// block must answer for it.
	function automatic pixel_result_t apply_pixel_command(input pixel_cmd_t c);
		pixel_result_t res;
		int            x, y, w, h, rx, ry, pos;
		logic [7:0]    mask;
		res.read_data     = '0;
		res.pixel_written = 1'b0;
		case (c.op)
			OP_CLEAR: begin
				foreach (frame_bytes[i]) frame_bytes[i] = '0;
			end
			OP_PLOT: begin
				x  = c.pos_x;
				y  = c.pos_y;
				w  = panel_width;
				h  = panel_height;
				rx = x;
				ry = y;
				case (panel_rotation)
					ROT_90: begin
						rx = w - y - 1;
						ry = x;
					end
					ROT_180: begin
						rx = w - x - 1;
						ry = h - y - 1;
					end
					ROT_270: begin
						rx = y;
						ry = h - x - 1;
					end
					default: ;
				endcase
				pos = rx + (ry / 8) * w;
				// Bounds are judged on the raw position; the rotated one must
				// still land inside the store.
				if (x >= 0 && x < w && y >= 0 && y < h && rx >= 0 && ry >= 0 &&
				    pos < STORE_BYTES) begin
					mask = 8'(1 << (ry % 8));
					case (c.color)
						COL_CLR: frame_bytes[pos] = frame_bytes[pos] & ~mask;
						COL_SET: frame_bytes[pos] = frame_bytes[pos] | mask;
						COL_TOG: frame_bytes[pos] = frame_bytes[pos] ^ mask;
						default: ;
					endcase
					res.pixel_written = 1'b1;
					last_plot_pos     = pos;
				end
			end
			OP_READ: begin
				if (c.byte_index < STORE_BYTES) res.read_data = frame_bytes[c.byte_index];
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic pixel_cmd_t make_cmd(input logic [1:0] op, input int x, input int y,
	                                        input logic [1:0] color, input int index);
		pixel_cmd_t c;
		c.op         = op;
		c.pos_x      = 9'(x);
		c.pos_y      = 9'(y);
		c.color      = color;
		c.byte_index = 10'(index);
		return c;
	endfunction

	// Mostly in-bounds plots and reads of bytes just drawn, with some edge
	// coordinates, fully random fields, spare ops and the odd clear mixed in.
	function automatic pixel_cmd_t random_pixel_command();
		pixel_cmd_t c;
		int         pick, w, h;
		w            = panel_width;
		h            = panel_height;
		c.op         = OP_PLOT;
		c.pos_x      = 9'($urandom);
		c.pos_y      = 9'($urandom);
		c.color      = 2'($urandom_range(3));
		c.byte_index = 10'($urandom);
		pick = $urandom_range(99);
		if (pick < 1) begin
			c.op = OP_CLEAR;
		end else if (pick < 4) begin
			c.op = OP_UNUSED;
		end else if (pick < 42) begin
			c.op = OP_READ;
			if ($urandom_range(9) < 6) c.byte_index = 10'(last_plot_pos);
		end else begin
			pick = $urandom_range(9);
			if (pick < 8) begin
				c.pos_x = 9'($urandom_range(w - 1));
				c.pos_y = 9'($urandom_range(h - 1));
			end else if (pick == 8) begin
				// Hug the border: one step outside on either side.
				c.pos_x = 9'(int'($urandom_range(w + 1)) - 1);
				c.pos_y = 9'(int'($urandom_range(h + 1)) - 1);
			end
		end
		return c;
	endfunction

	function automatic void report_mismatch(input string what, input logic [7:0] want,
	                                        input logic [7:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
	endfunction

	// Offer one command and hold it until the block takes it. Call at a clock
	// edge; returns at the edge where the transaction completed.
	task automatic send_command(input pixel_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid      <= 1'b1;
		cmd_if.op         <= c.op;
		cmd_if.pos_x      <= c.pos_x;
		cmd_if.pos_y      <= c.pos_y;
		cmd_if.color      <= c.color;
		cmd_if.byte_index <= c.byte_index;
		do @(posedge clk); while (!cmd_if.ready);
		pending_results.push_back(apply_pixel_command(c));
	endtask

	// Drop valid and wait until every owed result has come back.
	task automatic wait_until_drained();
		cmd_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Reprogram all three panel registers with the block idle.
	task automatic apply_config(input logic [WID_W-1:0] w, input logic [HGT_W-1:0] h,
	                            input logic [ROT_W-1:0] r);
		wait_until_drained();
		panel_width    = w;
		panel_height   = h;
		panel_rotation = r;
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_WIDTH;
		cfg_wdata <= CFG_DATA_W'(w);
		@(posedge clk);
		cfg_idx   <= CFG_HEIGHT;
		cfg_wdata <= CFG_DATA_W'(h);
		@(posedge clk);
		cfg_idx   <= CFG_ROTATION;
		cfg_wdata <= CFG_DATA_W'(r);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Reset register values, plain plots of every color, the border cases and
	// the spare op, all read back.
	task automatic test_plot_and_read();
		send_idle_pct = 0;
		rx_stall_pct  = 0;
		send_command(make_cmd(OP_READ, 0, 0, COL_CLR, 0));
		send_command(make_cmd(OP_PLOT, 0, 0, COL_SET, 0));
		send_command(make_cmd(OP_PLOT, 127, 63, COL_SET, 0));
		send_command(make_cmd(OP_READ, 0, 0, COL_CLR, 1023));
		send_command(make_cmd(OP_PLOT, 127, 63, COL_TOG, 0));
		send_command(make_cmd(OP_PLOT, 0, 1, COL_SET, 0));
		send_command(make_cmd(OP_PLOT, 0, 0, COL_KEEP, 0));
		send_command(make_cmd(OP_PLOT, 0, 0, COL_CLR, 0));
		send_command(make_cmd(OP_READ, 0, 0, COL_CLR, 0));
		// Out of bounds on each side, including the field extremes.
		send_command(make_cmd(OP_PLOT, -1, 0, COL_SET, 0));
		send_command(make_cmd(OP_PLOT, -256, 255, COL_SET, 0));
		send_command(make_cmd(OP_PLOT, 255, -256, COL_SET, 0));
		send_command(make_cmd(OP_PLOT, 128, 0, COL_SET, 0));
		send_command(make_cmd(OP_PLOT, 0, 64, COL_SET, 0));
		send_command(make_cmd(OP_UNUSED, 255, 255, COL_KEEP, 1023));
		send_command(make_cmd(OP_CLEAR, 0, 0, COL_CLR, 0));
		send_command(make_cmd(OP_READ, 0, 0, COL_CLR, 0));
	endtask

	// Each rotation, including positions that rotate off the store.
	task automatic test_rotation_modes();
		apply_config(8'd128, 7'd64, ROT_90);
		send_command(make_cmd(OP_PLOT, 5, 10, COL_SET, 0));
		send_command(make_cmd(OP_READ, 0, 0, COL_CLR, 117));
		send_command(make_cmd(OP_PLOT, 127, 0, COL_SET, 0));
		apply_config(8'd128, 7'd64, ROT_180);
		send_command(make_cmd(OP_PLOT, 0, 0, COL_SET, 0));
		send_command(make_cmd(OP_READ, 0, 0, COL_CLR, 1023));
		apply_config(8'd8, 7'd64, ROT_90);
		send_command(make_cmd(OP_PLOT, 0, 20, COL_SET, 0));
		apply_config(8'd8, 7'd64, ROT_270);
		send_command(make_cmd(OP_PLOT, 7, 3, COL_SET, 0));
		send_command(make_cmd(OP_READ, 0, 0, COL_CLR, 59));
		apply_config(8'd128, 7'd8, ROT_270);
		send_command(make_cmd(OP_PLOT, 100, 0, COL_SET, 0));
		apply_config(8'd1, 7'd1, ROT_0);
		send_command(make_cmd(OP_PLOT, 0, 0, COL_TOG, 0));
		send_command(make_cmd(OP_PLOT, 1, 0, COL_SET, 0));
		send_command(make_cmd(OP_READ, 0, 0, COL_CLR, 0));
	endtask

	// Random traffic under one idling profile; the first panel setting is
	// given, the rest are drawn at random.
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
	                                   input logic [WID_W-1:0] w0, input logic [HGT_W-1:0] h0,
	                                   input logic [ROT_W-1:0] r0);
		send_idle_pct = idle_pct;
		rx_stall_pct  = stall_pct;
		for (int blk = 0; blk < 4; blk++) begin
			if (blk == 0)
				apply_config(w0, h0, r0);
			else
				apply_config(WID_W'($urandom_range(1, 128)), HGT_W'($urandom_range(1, 64)),
				             ROT_W'($urandom_range(3)));
			repeat (80) send_command(random_pixel_command());
		end
	endtask

	// Hold the response side off for a long stretch while commands keep
	// coming, so the queue fills and cmd.ready must drop.
	task automatic test_output_backpressure();
		apply_config(8'd128, 7'd64, ROT_0);
		send_idle_pct    = 0;
		rx_stall_pct     = 0;
		hold_off_request = 300;
		repeat (40) send_command(random_pixel_command());
	endtask

	// Response side: ready follows the stall rate unless a hold-off is running.
	always @(posedge clk) begin
		if (hold_off_request != 0) begin
			hold_off_left    = hold_off_request;
			hold_off_request = 0;
		end
		if (hold_off_left != 0) begin
			hold_off_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Compare every response transaction with the oldest owed result.
	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unrequested response", 8'h00, rsp_if.read_data);
			end else begin
				want = pending_results.pop_front();
				if (rsp_if.read_data !== want.read_data)
					report_mismatch("read_data", want.read_data, rsp_if.read_data);
				if (rsp_if.pixel_written !== want.pixel_written)
					report_mismatch("pixel_written", 8'(want.pixel_written),
					                8'(rsp_if.pixel_written));
			end
		end
	end

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		cmd_if.valid      = 1'b0;
		cmd_if.op         = OP_CLEAR;
		cmd_if.pos_x      = '0;
		cmd_if.pos_y      = '0;
		cmd_if.color      = COL_CLR;
		cmd_if.byte_index = '0;
		rsp_if.ready      = 1'b0;
		cfg_we            = 1'b0;
		cfg_idx           = CFG_WIDTH;
		cfg_wdata         = '0;
		panel_width       = WIDTH_RST;
		panel_height      = HEIGHT_RST;
		panel_rotation    = ROT_RST;
		last_plot_pos     = 0;
		mismatch_count    = 0;
		send_idle_pct     = 0;
		rx_stall_pct      = 0;
		hold_off_request  = 0;
		hold_off_left     = 0;
		foreach (frame_bytes[i]) frame_bytes[i] = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_plot_and_read();
		test_rotation_modes();
		test_random_traffic(0, 0, 8'd128, 7'd64, ROT_0);
		test_random_traffic(77, 0, 8'd1, 7'd64, ROT_90);
		test_random_traffic(0, 77, 8'd128, 7'd1, ROT_180);
		test_random_traffic(20, 20, 8'd1, 7'd1, ROT_270);
		test_output_backpressure();

		// Drain, then leave room for any stray response to show up.
		wait_until_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
